// ----- rtl/fixed_partition_fit_allocator_top_defines.svh -----
// ----------------------------------------------------------------------------
// Fixed partition allocator assertion macros
// Shared assertion forms for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define FPFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpfa assertion failed");

// Next-cycle implication, sampled on clk_i and held off during reset.
`define FPFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpfa assertion failed");

`endif

// ----- rtl/fpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed partition allocator package
// Widths, types and codes shared by the allocator files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpfa_pkg;

  localparam int MaxParts   = 5;
  localparam int SizeBits   = 16;
  localparam int IdxBits    = (MaxParts > 1) ? $clog2(MaxParts) : 1;
  localparam int CountBits  = 3;
  localparam int WasteBits  = 19;
  localparam int JobCntBits = 8;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = SizeBits;

  typedef logic [SizeBits-1:0]   size_t;
  typedef logic [IdxBits-1:0]    idx_t;
  typedef logic [CountBits-1:0]  count_t;
  typedef logic [WasteBits-1:0]  waste_t;
  typedef logic [JobCntBits-1:0] jobcnt_t;
  typedef logic [CfgIdxBits-1:0] cfgidx_t;

  typedef enum logic [1:0] {
    POL_FIRST,
    POL_BEST,
    POL_WORST,
    POL_NEXT
  } policy_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_POLICY,
    CFG_PART_COUNT,
    CFG_SIZE_0,
    CFG_SIZE_1,
    CFG_SIZE_2,
    CFG_SIZE_3,
    CFG_SIZE_4
  } cfg_idx_e;

  typedef enum logic {
    REQ_CLEAR,
    REQ_PLACE
  } req_type_e;

endpackage

`default_nettype wire

// ----- rtl/fpfa_if.sv -----
// ----------------------------------------------------------------------------
// Fixed partition allocator channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fpfa_req_if;
  logic             valid;
  logic             ready;
  logic             req_type;
  fpfa_pkg::size_t  job_size;

  modport source (output valid, output req_type, output job_size, input ready);
  modport sink   (input valid, input req_type, input job_size, output ready);
endinterface

interface fpfa_res_if;
  logic             valid;
  logic             ready;
  logic             placed;
  fpfa_pkg::idx_t   part_index;
  fpfa_pkg::size_t  leftover;
  fpfa_pkg::jobcnt_t job_number;
  fpfa_pkg::waste_t total_waste;

  modport source (output valid, output placed, output part_index, output leftover,
                  output job_number, output total_waste, input ready);
  modport sink   (input valid, input placed, input part_index, input leftover,
                  input job_number, input total_waste, output ready);
endinterface

interface fpfa_cfg_if;
  logic                                 valid;
  logic                                 ready;
  fpfa_pkg::cfgidx_t                    index;
  logic [fpfa_pkg::CfgDataBits-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/fixed_partition_fit_allocator_top.sv -----
// A request is captured in the input register; its result is registered and
// offered once the result register is free or being taken.
// Throughput: one request per cycle while results are taken; all partition
// compares and the selection sit between the input and result registers.
// Reset: asynchronous, active low; all partitions free, counters zero,
// policy first fit, five partitions of size zero. Configuration is always ready.
// ----------------------------------------------------------------------------
// Fixed partition fit allocator
// Places jobs into fixed partitions by first, best, worst or next fit, and frees all partitions on a clear request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_partition_fit_allocator_top (
  input  wire   clk_i,
  input  wire   rst_ni,
  fpfa_req_if.sink   req_i,
  fpfa_res_if.source res_o,
  fpfa_cfg_if.sink   cfg_i
);

  logic                  in_valid_q;
  logic                  in_req_q;
  fpfa_pkg::size_t       in_job_q;

  fpfa_pkg::policy_e     policy_q;
  fpfa_pkg::count_t      part_count_q;
  fpfa_pkg::size_t       part_size_q [fpfa_pkg::MaxParts];

  logic [fpfa_pkg::MaxParts-1:0] busy_q, busy_d;
  fpfa_pkg::waste_t      alloc_q, alloc_d;
  fpfa_pkg::idx_t        next_start_q, next_start_d;
  fpfa_pkg::jobcnt_t     job_cnt_q, job_cnt_d;

  logic                  res_valid_q;
  logic                  res_placed_q;
  fpfa_pkg::idx_t        res_index_q;
  fpfa_pkg::size_t       res_left_q;
  fpfa_pkg::jobcnt_t     res_jobnum_q;
  fpfa_pkg::waste_t      res_waste_q;

  logic                  fire;
  logic                  is_place;
  fpfa_pkg::idx_t        n_use;
  fpfa_pkg::idx_t        start;
  logic [fpfa_pkg::MaxParts-1:0] eligible;
  logic                  ff_found, sel_found, nf_hi_found, found;
  fpfa_pkg::idx_t        ff_pick, sel_pick, nf_hi_pick, pick;
  fpfa_pkg::size_t       sel_size, pick_size;
  fpfa_pkg::waste_t      size_sum, waste;
  fpfa_pkg::cfgidx_t     size_slot;

  assign fire        = in_valid_q & (~res_valid_q | res_o.ready);
  assign req_i.ready = ~in_valid_q | fire;
  assign cfg_i.ready = 1'b1;
  assign is_place    = (in_req_q == fpfa_pkg::REQ_PLACE);
  assign size_slot   = cfg_i.index - fpfa_pkg::cfgidx_t'(fpfa_pkg::CFG_SIZE_0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_req_q <= req_i.req_type;
      in_job_q <= req_i.job_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= fpfa_pkg::POL_FIRST;
      part_count_q <= fpfa_pkg::count_t'(fpfa_pkg::MaxParts);
      for (int i = 0; i < fpfa_pkg::MaxParts; i++) begin
        part_size_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        fpfa_pkg::CFG_POLICY: begin
          policy_q <= fpfa_pkg::policy_e'(cfg_i.data[1:0]);
        end
        fpfa_pkg::CFG_PART_COUNT: begin
          part_count_q <= cfg_i.data[fpfa_pkg::CountBits-1:0];
        end
        default: begin
          if (cfg_i.index >= fpfa_pkg::cfgidx_t'(fpfa_pkg::CFG_SIZE_0) &&
              size_slot < fpfa_pkg::cfgidx_t'(fpfa_pkg::MaxParts)) begin
            part_size_q[fpfa_pkg::idx_t'(size_slot)] <= cfg_i.data[fpfa_pkg::SizeBits-1:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    if (part_count_q == '0) begin
      n_use = fpfa_pkg::idx_t'(1);
    end else if (part_count_q > fpfa_pkg::count_t'(fpfa_pkg::MaxParts)) begin
      n_use = fpfa_pkg::idx_t'(fpfa_pkg::MaxParts);
    end else begin
      n_use = fpfa_pkg::idx_t'(part_count_q);
    end
    start = (next_start_q < n_use) ? next_start_q : '0;
    for (int i = 0; i < fpfa_pkg::MaxParts; i++) begin
      eligible[i] = (fpfa_pkg::idx_t'(i) < n_use) && !busy_q[i] &&
                    (in_job_q <= part_size_q[i]);
    end
  end

  always_comb begin
    ff_found    = 1'b0;
    ff_pick     = '0;
    nf_hi_found = 1'b0;
    nf_hi_pick  = '0;
    for (int i = fpfa_pkg::MaxParts - 1; i >= 0; i--) begin
      if (eligible[i]) begin
        ff_found = 1'b1;
        ff_pick  = fpfa_pkg::idx_t'(i);
        if (fpfa_pkg::idx_t'(i) >= start) begin
          nf_hi_found = 1'b1;
          nf_hi_pick  = fpfa_pkg::idx_t'(i);
        end
      end
    end
  end

  always_comb begin
    sel_found = 1'b0;
    sel_pick  = '0;
    sel_size  = '0;
    for (int i = 0; i < fpfa_pkg::MaxParts; i++) begin
      if (eligible[i]) begin
        if (!sel_found ||
            (policy_q == fpfa_pkg::POL_BEST && part_size_q[i] < sel_size) ||
            (policy_q == fpfa_pkg::POL_WORST && part_size_q[i] > sel_size)) begin
          sel_pick = fpfa_pkg::idx_t'(i);
          sel_size = part_size_q[i];
        end
        sel_found = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (policy_q)
      fpfa_pkg::POL_FIRST: begin
        found = ff_found;
        pick  = ff_pick;
      end
      fpfa_pkg::POL_BEST, fpfa_pkg::POL_WORST: begin
        found = sel_found;
        pick  = sel_pick;
      end
      fpfa_pkg::POL_NEXT: begin
        found = ff_found;
        pick  = nf_hi_found ? nf_hi_pick : ff_pick;
      end
      default: begin
        found = 1'b0;
        pick  = '0;
      end
    endcase
    found     = found & is_place;
    pick_size = part_size_q[pick];
  end

  always_comb begin
    busy_d       = busy_q;
    alloc_d      = alloc_q;
    next_start_d = next_start_q;
    job_cnt_d    = job_cnt_q;
    if (!is_place) begin
      busy_d       = '0;
      alloc_d      = '0;
      next_start_d = '0;
      job_cnt_d    = '0;
    end else begin
      if (job_cnt_q != '1) begin
        job_cnt_d = job_cnt_q + fpfa_pkg::jobcnt_t'(1);
      end
      if (found) begin
        busy_d[pick] = 1'b1;
        alloc_d      = alloc_q + fpfa_pkg::waste_t'(in_job_q);
        if (policy_q == fpfa_pkg::POL_NEXT) begin
          next_start_d = pick;
        end
      end
    end
    size_sum = '0;
    for (int i = 0; i < fpfa_pkg::MaxParts; i++) begin
      if (fpfa_pkg::idx_t'(i) < n_use) begin
        size_sum = size_sum + fpfa_pkg::waste_t'(part_size_q[i]);
      end
    end
    waste = (size_sum >= alloc_d) ? (size_sum - alloc_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= '0;
      alloc_q      <= '0;
      next_start_q <= '0;
      job_cnt_q    <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        busy_q       <= busy_d;
        alloc_q      <= alloc_d;
        next_start_q <= next_start_d;
        job_cnt_q    <= job_cnt_d;
        res_valid_q  <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_placed_q <= found;
      res_index_q  <= found ? pick : '0;
      res_left_q   <= found ? (pick_size - in_job_q) : '0;
      res_jobnum_q <= is_place ? job_cnt_q : '0;
      res_waste_q  <= waste;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.placed      = res_placed_q;
  assign res_o.part_index  = res_index_q;
  assign res_o.leftover    = res_left_q;
  assign res_o.job_number  = res_jobnum_q;
  assign res_o.total_waste = res_waste_q;

endmodule

`default_nettype wire

// ----- rtl/fpfa_checker.sv -----
// ----------------------------------------------------------------------------
// Fixed partition allocator checker
// Port-level assertions on the allocator result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_partition_fit_allocator_top_defines.svh"

module fpfa_checker (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     res_valid_i,
  input wire                     res_ready_i,
  input wire                     res_placed_i,
  input wire [fpfa_pkg::IdxBits-1:0]  res_index_i,
  input wire [fpfa_pkg::SizeBits-1:0] res_left_i
);

  // A result that is not taken stays offered.
  `FPFA_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i)

  // A request that found no partition reports neither index nor leftover.
  `FPFA_ASSERT_NOW(a_unplaced_zero, res_valid_i && !res_placed_i, res_index_i == '0 && res_left_i == '0)

  // A placed request names a partition that exists.
  `FPFA_ASSERT_NOW(a_index_range, res_valid_i && res_placed_i, res_index_i < fpfa_pkg::IdxBits'(fpfa_pkg::MaxParts))

endmodule

bind fixed_partition_fit_allocator_top fpfa_checker u_fpfa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_placed_i (res_o.placed),
  .res_index_i  (res_o.part_index),
  .res_left_i   (res_o.leftover)
);

`default_nettype wire

// ----- tb/fixed_partition_fit_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// Fixed partition fit allocator testbench
// Drives clear and place requests under first, best, worst and next fit with
// changing partition setups, predicts every result with an internal model of
// the partitions, and checks each result field against it while both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_top_tb;
  import fpfa_pkg::*;

  localparam int CycleLimit = 300000;

  typedef struct packed {
    logic    placed;
    idx_t    part_index;
    size_t   leftover;
    jobcnt_t job_number;
    waste_t  total_waste;
  } alloc_result_t;

  logic clk;
  logic rst_n;

  fpfa_req_if req_if ();
  fpfa_res_if res_if ();
  fpfa_cfg_if cfg_if ();

  fixed_partition_fit_allocator_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  policy_e     cur_policy = POL_FIRST;
  count_t      cur_count = count_t'(MaxParts);
  size_t       part_cap [MaxParts] = '{default: '0};
  bit          part_busy [MaxParts] = '{default: 1'b0};
  int unsigned alloc_sum = 0;
  int unsigned resume_at = 0;
  int unsigned job_seq = 0;

  alloc_result_t pending_results [$];
  int            errors = 0;
  int            cycle_count = 0;
  bit            tx_idle = 1'b1;
  bit            rx_idle = 1'b1;
  bit            res_fire = 1'b0;
  int            rx_hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic alloc_result_t allocate_job(input req_type_e kind, input size_t job);
    int unsigned n, start, j, i, t, pick, sum;
    bit found;
    alloc_result_t r;
    n = (cur_count == 0) ? 1 : ((cur_count > MaxParts) ? MaxParts : cur_count);
    r = '0;
    found = 1'b0;
    pick = 0;
    if (kind == REQ_CLEAR) begin
      for (i = 0; i < MaxParts; i++) part_busy[i] = 1'b0;
      alloc_sum = 0;
      resume_at = 0;
      job_seq = 0;
    end else begin
      r.job_number = jobcnt_t'(job_seq);
      if (job_seq < 255) job_seq++;
      if (cur_policy == POL_NEXT) begin
        start = (resume_at < n) ? resume_at : 0;
        for (t = 0; t < n && !found; t++) begin
          j = start + t;
          if (j >= n) j -= n;
          if (!part_busy[j] && job <= part_cap[j]) begin
            found = 1'b1;
            pick = j;
          end
        end
      end else begin
        for (i = 0; i < n; i++) begin
          if (!part_busy[i] && job <= part_cap[i]) begin
            if (!found) begin
              found = 1'b1;
              pick = i;
            end else if (cur_policy == POL_BEST && part_cap[i] < part_cap[pick]) begin
              pick = i;
            end else if (cur_policy == POL_WORST && part_cap[i] > part_cap[pick]) begin
              pick = i;
            end
          end
        end
      end
      if (found) begin
        part_busy[pick] = 1'b1;
        alloc_sum += job;
        if (cur_policy == POL_NEXT) resume_at = pick;
        r.placed = 1'b1;
        r.part_index = idx_t'(pick);
        r.leftover = part_cap[pick] - job;
      end
    end
    sum = 0;
    for (i = 0; i < n; i++) sum += part_cap[i];
    r.total_waste = (sum < alloc_sum) ? '0 : waste_t'(sum - alloc_sum);
    return r;
  endfunction

  task automatic send_request(input req_type_e kind, input size_t job);
    int gap;
    bit fire;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= kind;
    req_if.job_size <= job;
    do begin
      @(negedge clk);
      fire = (req_if.ready === 1'b1);
      @(posedge clk);
    end while (!fire);
    pending_results.push_back(allocate_job(kind, job));
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] value);
    bit fire;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do begin
      @(negedge clk);
      fire = (cfg_if.ready === 1'b1);
      @(posedge clk);
    end while (!fire);
    case (idx)
      CFG_POLICY:     cur_policy = policy_e'(value[1:0]);
      CFG_PART_COUNT: cur_count = value[2:0];
      default:        part_cap[idx - CFG_SIZE_0] = value;
    endcase
  endtask

  task automatic set_config(input policy_e pol, input count_t cnt, input size_t sz [MaxParts]);
    int k;
    write_reg(CFG_POLICY, CfgDataBits'(pol));
    write_reg(CFG_PART_COUNT, CfgDataBits'(cnt));
    for (k = 0; k < MaxParts; k++) write_reg(cfg_idx_e'(CFG_SIZE_0 + k), sz[k]);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_random_config();
    size_t sz [MaxParts];
    int mode, k;
    count_t cnt;
    mode = $urandom_range(0, 3);
    for (k = 0; k < MaxParts; k++) begin
      case (mode)
        0:       sz[k] = size_t'($urandom_range(0, 300));
        1:       sz[k] = size_t'($urandom_range(0, 65535));
        2:       sz[k] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: sz[k] = $urandom_range(0, 1) ? size_t'($urandom_range(0, 300))
                                             : size_t'($urandom_range(0, 65535));
      endcase
    end
    case ($urandom_range(0, 9))
      0:       cnt = '0;
      1:       cnt = count_t'($urandom_range(6, 7));
      default: cnt = count_t'($urandom_range(1, 5));
    endcase
    set_config(policy_e'($urandom_range(0, 3)), cnt, sz);
  endtask

  function automatic size_t random_job_size();
    int k, d;
    k = $urandom_range(0, MaxParts - 1);
    d = $urandom_range(0, 50);
    case ($urandom_range(0, 7))
      0, 1:    return size_t'($urandom_range(0, 65535));
      2:       return part_cap[k];
      3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return (part_cap[k] > d) ? part_cap[k] - size_t'(d) : '0;
    endcase
  endfunction

  task automatic test_reset_state();
    send_request(REQ_PLACE, 16'd0);
    send_request(REQ_PLACE, 16'd1);
    send_request(REQ_CLEAR, 16'hFFFF);
  endtask

  task automatic test_first_fit();
    wait_for_results();
    set_config(POL_FIRST, 3'd5, '{16'd100, 16'd500, 16'd200, 16'd300, 16'hFFFF});
    send_request(REQ_PLACE, 16'd150);
    send_request(REQ_PLACE, 16'hFFFF);
    send_request(REQ_PLACE, 16'd0);
    send_request(REQ_PLACE, 16'd250);
    send_request(REQ_PLACE, 16'd300);
  endtask

  task automatic test_best_fit();
    wait_for_results();
    set_config(POL_BEST, 3'd5, '{16'd300, 16'd200, 16'd200, 16'hFFFF, 16'd0});
    send_request(REQ_CLEAR, 16'd0);
    send_request(REQ_PLACE, 16'd150);
    send_request(REQ_PLACE, 16'd150);
    send_request(REQ_PLACE, 16'd0);
  endtask

  task automatic test_worst_fit();
    wait_for_results();
    set_config(POL_WORST, 3'd5, '{16'hFFFF, 16'd1000, 16'hFFFF, 16'd5, 16'd5});
    send_request(REQ_CLEAR, 16'd0);
    send_request(REQ_PLACE, 16'd5);
    send_request(REQ_PLACE, 16'd5);
  endtask

  task automatic test_next_fit_and_counts();
    wait_for_results();
    set_config(POL_NEXT, 3'd5, '{16'd100, 16'd100, 16'd10, 16'd10, 16'd100});
    send_request(REQ_CLEAR, 16'd0);
    send_request(REQ_PLACE, 16'd50);
    send_request(REQ_PLACE, 16'd5);
    send_request(REQ_PLACE, 16'd50);
    // The resume point now lies beyond a count of four, so the search restarts at zero.
    wait_for_results();
    write_reg(CFG_PART_COUNT, 16'd4);
    cfg_if.valid <= 1'b0;
    send_request(REQ_PLACE, 16'd5);
    // Shrinking a busy partition drives the waste below zero, which reads as zero.
    wait_for_results();
    write_reg(CFG_SIZE_0, 16'd0);
    write_reg(CFG_PART_COUNT, 16'd0);
    cfg_if.valid <= 1'b0;
    send_request(REQ_PLACE, 16'd0);
    wait_for_results();
    write_reg(CFG_PART_COUNT, 16'd7);
    cfg_if.valid <= 1'b0;
    send_request(REQ_PLACE, 16'd1);
  endtask

  task automatic test_job_number_saturation();
    int k;
    wait_for_results();
    set_config(POL_FIRST, 3'd5, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_request(REQ_CLEAR, 16'd0);
    for (k = 0; k < 270; k++) begin
      send_request(REQ_PLACE, ($urandom_range(0, 49) == 0) ? 16'd0
                                                           : size_t'($urandom_range(1, 65535)));
    end
  endtask

  task automatic test_input_backpressure();
    int k;
    wait_for_results();
    load_random_config();
    tx_idle = 1'b0;
    rx_hold_left <= 80;
    send_request(REQ_CLEAR, '0);
    for (k = 0; k < 40; k++) send_request((k % 9 == 0) ? REQ_CLEAR : REQ_PLACE, random_job_size());
    wait_for_results();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_rounds(input int phases);
    int p, k, count;
    for (p = 0; p < phases; p++) begin
      wait_for_results();
      load_random_config();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) send_request(REQ_CLEAR, size_t'($urandom_range(0, 65535)));
      count = $urandom_range(20, 60);
      for (k = 0; k < count; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          send_request(REQ_CLEAR, size_t'($urandom_range(0, 65535)));
        end else begin
          send_request(REQ_PLACE, random_job_size());
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  initial begin : result_check
    alloc_result_t want;
    forever begin
      @(negedge clk);
      res_fire = (rst_n === 1'b1) && (res_if.valid === 1'b1) && (res_if.ready === 1'b1);
      if (res_fire) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request pending, expected none, actual placed %0b",
                   $time, res_if.placed);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("placed", want.placed, res_if.placed);
          check_field("part_index", want.part_index, res_if.part_index);
          check_field("leftover", want.leftover, res_if.leftover);
          check_field("job_number", want.job_number, res_if.job_number);
          check_field("total_waste", want.total_waste, res_if.total_waste);
        end
      end
    end
  end

  initial begin : result_ready_driver
    int stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_fire) stall_left = rx_idle ? $urandom_range(0, 10) : 0;
      if (rx_hold_left > 0 || stall_left > 0) begin
        res_if.ready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : result_hold_counter
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) rx_hold_left = rx_hold_left - 1;
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_CLEAR;
    req_if.job_size = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_POLICY;
    cfg_if.data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_first_fit();
    test_best_fit();
    test_worst_fit();
    test_next_fit_and_counts();
    test_job_number_saturation();
    test_input_backpressure();
    test_random_rounds(32);
    wait_for_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
